>>> rtl/ehwq_pkg.sv
// Shared codes and control types for the Euler histogram window query block.
package ehwq_pkg;

  // Input item operation codes
  localparam logic [2:0] FUNC_FACE  = 3'd0;
  localparam logic [2:0] FUNC_VERT  = 3'd1;
  localparam logic [2:0] FUNC_HEDGE = 3'd2;
  localparam logic [2:0] FUNC_VEDGE = 3'd3;
  localparam logic [2:0] FUNC_QUERY = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [2:0] REG_END_X       = 3'd2;
  localparam logic [2:0] REG_END_Y       = 3'd3;
  localparam logic [2:0] REG_CELL_WIDTH  = 3'd4;
  localparam logic [2:0] REG_CELL_HEIGHT = 3'd5;
  localparam logic [2:0] REG_COLS        = 3'd6;
  localparam logic [2:0] REG_ROWS        = 3'd7;

  // Store selects, one bit per count table
  localparam int SEL_FACE  = 0;
  localparam int SEL_VERT  = 1;
  localparam int SEL_HEDGE = 2;
  localparam int SEL_VEDGE = 3;

  // Write request to the count store
  typedef struct packed {
    logic       clear;
    logic [3:0] sel;
  } wreq_t;

  // Divider control and status
  typedef struct packed {
    logic       start;
    logic [5:0] steps;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/ehwq_if.sv
// Handshake channels for query/load items and for estimate results.
interface ehwq_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic [6:0]         cell_x;
  logic [6:0]         cell_y;
  logic [31:0]        count_value;
  logic signed [31:0] query_min_x;
  logic signed [31:0] query_min_y;
  logic signed [31:0] query_max_x;
  logic signed [31:0] query_max_y;

  modport source (output valid, func, cell_x, cell_y, count_value,
                  query_min_x, query_min_y, query_max_x, query_max_y, input ready);
  modport sink (input valid, func, cell_x, cell_y, count_value,
                query_min_x, query_min_y, query_max_x, query_max_y, output ready);
endinterface

interface ehwq_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] estimate;
  logic               saturated;

  modport source (output valid, estimate, saturated, input ready);
  modport sink (input valid, estimate, saturated, output ready);
endinterface

>>> rtl/euler_histogram_window_query.sv
// Top level: Euler histogram store and window count estimator sequencer.
//
//  channel  dir  handshake         payload
//  req      in   valid/ready       func, cell_x, cell_y, count_value, query window
//  rsp      out  valid/ready       estimate, saturated (one per query)
//  cfg      in   cfg_we            cfg_idx, cfg_data
//
// A load is written to its table when it is accepted. A query clips the window and finds
// the walk bounds, then visits each cell of the walk, computing the column tics at the first
// cell of a column; each cell uses up to two fraction divisions, one face weight product
// and one product per nonzero term, on the shared bit-serial divider and the single
// multiplier. The rounding states S_FIN1 to S_FIN3 and the output state S_OUT follow.
// After reset a clearing sweep over (MAX_COLS+1)*(MAX_ROWS+1) table rows runs; req is not
// ready meanwhile. A finished estimate waits in the output register while the
// next item is taken; a later query stalls at its end until that slot is free.
module euler_histogram_window_query import ehwq_pkg::*; #(
  parameter int MAX_COLS   = 64,
  parameter int MAX_ROWS   = 64,
  parameter int COUNT_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  ehwq_req_if.sink    req,
  ehwq_rsp_if.source  rsp,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_data
);

  localparam int QB   = ($clog2(MAX_COLS + 1) > $clog2(MAX_ROWS + 1)) ?
                        $clog2(MAX_COLS + 1) : $clog2(MAX_ROWS + 1);
  localparam int VD   = (MAX_COLS + 1) * (MAX_ROWS + 1);
  localparam int CW   = $clog2(VD + 1);
  localparam int TW   = QB + 34;
  localparam int DW   = TW + FRAC_BITS + 1;
  localparam int FQ   = FRAC_BITS + 1;
  localparam int QW   = (FQ > QB) ? FQ : QB;
  localparam int MA   = (COUNT_BITS > FQ) ? COUNT_BITS : FQ;
  localparam int PW   = MA + FQ;
  localparam int ACCW = COUNT_BITS + FRAC_BITS + 2 + $clog2(2 * VD);
  localparam int DFW  = ACCW + 1;
  localparam int CMPW = (DFW > 64) ? DFW : 64;

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_CHK   = 5'd2;
  localparam logic [4:0] S_BND   = 5'd3;
  localparam logic [4:0] S_BNDW  = 5'd4;
  localparam logic [4:0] S_TX    = 5'd5;
  localparam logic [4:0] S_TY    = 5'd6;
  localparam logic [4:0] S_EV    = 5'd7;
  localparam logic [4:0] S_DX    = 5'd8;
  localparam logic [4:0] S_DXW   = 5'd9;
  localparam logic [4:0] S_DY    = 5'd10;
  localparam logic [4:0] S_DYW   = 5'd11;
  localparam logic [4:0] S_FF    = 5'd12;
  localparam logic [4:0] S_FF2   = 5'd13;
  localparam logic [4:0] S_TERM  = 5'd14;
  localparam logic [4:0] S_ADD   = 5'd15;
  localparam logic [4:0] S_NEXT  = 5'd16;
  localparam logic [4:0] S_FIN1  = 5'd17;
  localparam logic [4:0] S_FIN2  = 5'd18;
  localparam logic [4:0] S_FIN3  = 5'd19;
  localparam logic [4:0] S_OUT   = 5'd20;

  // Configuration registers
  logic signed [31:0] org_x, org_y, end_x, end_y;
  logic [30:0]        cell_w, cell_h;
  logic [6:0]         ncols, nrows;

  // Sequencer and walk state
  logic [4:0]           state;
  logic [CW-1:0]        clr_idx;
  logic signed [TW-1:0] qx0, qy0, qx1, qy1;
  logic [1:0]           bsel;
  logic [QB-1:0]        xa, xb, ya, yb, x, y;
  logic signed [TW-1:0] tx0, tx1, ty0, ty1;
  logic signed [TW-1:0] ix, iy, lenx, leny;
  logic [3:0]           ten;
  logic                 need_fx, need_fy;
  logic [FQ-1:0]        fx, fy, ff;
  logic [1:0]           tsel;
  logic [PW-1:0]        prod;
  logic [ACCW-1:0]      pos, neg;
  logic signed [DFW-1:0] diff;
  logic [DFW-1:0]       rnd;
  logic                 sign_r;
  logic signed [47:0]   res_est;
  logic                 res_sat;
  logic                 out_valid;
  logic signed [47:0]   out_est;
  logic                 out_sat;

  // Store and divider links
  wreq_t                 wreq;
  logic [QB-1:0]         wx, wy;
  logic [COUNT_BITS-1:0] face_q, vert_q, hedge_q, vedge_q;
  div_ctl_t              dctl;
  div_stat_t             dstat;
  logic [DW-1:0]         dnum, ddsh;
  logic [QW-1:0]         dquo;

  // Effective grid and cell sizes
  logic [30:0]   cwe, che;
  logic [QB-1:0] nc, nr;
  always_comb begin
    cwe = (cell_w == '0) ? 31'd1 : cell_w;
    che = (cell_h == '0) ? 31'd1 : cell_h;
    if (ncols == '0) nc = QB'(1);
    else if (32'(ncols) > MAX_COLS) nc = QB'(MAX_COLS);
    else nc = QB'(ncols);
    if (nrows == '0) nr = QB'(1);
    else if (32'(nrows) > MAX_ROWS) nr = QB'(MAX_ROWS);
    else nr = QB'(nrows);
  end

  function automatic logic signed [TW-1:0] tic_at(input logic [QB-1:0] i,
      input logic [QB-1:0] n, input logic signed [31:0] org, input logic [30:0] sz,
      input logic signed [31:0] last);
    logic [30+QB:0] p;
    p = (31 + QB)'(sz) * (31 + QB)'(i);
    return (i < n) ? (TW'(org) + TW'($signed({1'b0, p}))) : TW'(last);
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      org_x  <= '0;
      org_y  <= '0;
      end_x  <= '0;
      end_y  <= '0;
      cell_w <= 31'd65536;
      cell_h <= 31'd65536;
      ncols  <= 7'd64;
      nrows  <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ORIGIN_X:    org_x  <= cfg_data;
        REG_ORIGIN_Y:    org_y  <= cfg_data;
        REG_END_X:       end_x  <= cfg_data;
        REG_END_Y:       end_y  <= cfg_data;
        REG_CELL_WIDTH:  cell_w <= cfg_data[30:0];
        REG_CELL_HEIGHT: cell_h <= cfg_data[30:0];
        REG_COLS:        ncols  <= cfg_data[6:0];
        REG_ROWS:        nrows  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Input handshake and load decode
  logic accept;
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign wx        = QB'(req.cell_x);
  assign wy        = QB'(req.cell_y);

  always_comb begin
    wreq.clear = (state == S_CLEAR);
    wreq.sel   = '0;
    if (accept) begin
      case (req.func)
        FUNC_FACE:  wreq.sel[SEL_FACE]  = 32'(req.cell_x) < MAX_COLS &&
                                          32'(req.cell_y) < MAX_ROWS;
        FUNC_VERT:  wreq.sel[SEL_VERT]  = 32'(req.cell_x) <= MAX_COLS &&
                                          32'(req.cell_y) <= MAX_ROWS;
        FUNC_HEDGE: wreq.sel[SEL_HEDGE] = 32'(req.cell_x) < MAX_COLS &&
                                          32'(req.cell_y) <= MAX_ROWS;
        FUNC_VEDGE: wreq.sel[SEL_VEDGE] = 32'(req.cell_x) <= MAX_COLS &&
                                          32'(req.cell_y) < MAX_ROWS;
        default: ;
      endcase
    end
  end

  // Window clipped to the extent
  logic signed [31:0] cx0, cy0, cx1, cy1;
  always_comb begin
    cx0 = (req.query_min_x > org_x) ? req.query_min_x : org_x;
    cy0 = (req.query_min_y > org_y) ? req.query_min_y : org_y;
    cx1 = (req.query_max_x < end_x) ? req.query_max_x : end_x;
    cy1 = (req.query_max_y < end_y) ? req.query_max_y : end_y;
  end

  // Walk bound step: offset over cell size, clamped to the grid
  logic                 b_lo, b_ax, big;
  logic signed [TW-1:0] boff;
  logic [DW-1:0]        bnum;
  logic [30:0]          bsz;
  logic [QB-1:0]        bn, bq, bres;
  always_comb begin
    b_lo = (bsel[0] == 1'b0);
    b_ax = bsel[1];
    if (b_ax) boff = (b_lo ? qy0 : qy1) - TW'(org_y);
    else      boff = (b_lo ? qx0 : qx1) - TW'(org_x);
    bnum = DW'($unsigned(boff));
    bsz  = b_ax ? che : cwe;
    bn   = b_ax ? nr : nc;
    big  = bnum >= (DW'(bsz) << QB);
    bq   = QB'(dquo);
    if (b_lo) bres = (big || bq > bn) ? bn : bq;
    else      bres = (!big && bq < bn) ? bq + QB'(1) : bn;
  end

  // Divider operand select
  always_comb begin
    dctl.start = 1'b0;
    dctl.steps = 6'(FQ);
    dnum       = DW'($unsigned(ix)) << FRAC_BITS;
    ddsh       = DW'($unsigned(lenx)) << FRAC_BITS;
    case (state)
      S_BND: begin
        dctl.start = !big;
        dctl.steps = 6'(QB);
        dnum       = bnum;
        ddsh       = DW'(bsz) << (QB - 1);
      end
      S_DX: dctl.start = need_fx;
      S_DY: begin
        dctl.start = need_fy;
        dnum       = DW'($unsigned(iy)) << FRAC_BITS;
        ddsh       = DW'($unsigned(leny)) << FRAC_BITS;
      end
      default: ;
    endcase
  end

  // Per-cell term flags from tics and clipped window
  logic xin, yin, xlive, ylive;
  logic signed [TW-1:0] ix_c, iy_c;
  always_comb begin
    xin   = tx0 <= qx1 && tx1 >= qx0;
    yin   = ty0 <= qy1 && ty1 >= qy0;
    xlive = x < nc && xin && tx1 > tx0;
    ylive = y < nr && yin && ty1 > ty0;
    ix_c  = ((tx1 < qx1) ? tx1 : qx1) - ((tx0 > qx0) ? tx0 : qx0);
    iy_c  = ((ty1 < qy1) ? ty1 : qy1) - ((ty0 > qy0) ? ty0 : qy0);
  end

  // Shared multiplier operand select
  logic [MA-1:0] mul_a;
  logic [FQ-1:0] mul_b;
  always_comb begin
    mul_a = MA'(fx);
    mul_b = fy;
    if (state == S_TERM) begin
      case (tsel)
        2'd0: begin mul_a = MA'(face_q);  mul_b = ff; end
        2'd1: begin mul_a = MA'(vert_q);  mul_b = FQ'(1) << FRAC_BITS; end
        2'd2: begin mul_a = MA'(hedge_q); mul_b = fx; end
        default: begin mul_a = MA'(vedge_q); mul_b = fy; end
      endcase
    end
  end

  // Rounded magnitude and saturation
  logic [DFW-1:0]  mag_full;
  logic [CMPW-1:0] mag_ext, lim_ext;
  logic            sat_c;
  logic [47:0]     mag48;
  always_comb begin
    mag_full = rnd >> FRAC_BITS;
    mag_ext  = CMPW'(mag_full);
    lim_ext  = sign_r ? (CMPW'(1) << 47) : ((CMPW'(1) << 47) - CMPW'(1));
    sat_c    = mag_ext > lim_ext;
    mag48    = sat_c ? lim_ext[47:0] : mag_ext[47:0];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + CW'(1);
          if (32'(clr_idx) == VD - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept && req.func == FUNC_QUERY) begin
            qx0   <= TW'(cx0);
            qy0   <= TW'(cy0);
            qx1   <= TW'(cx1);
            qy1   <= TW'(cy1);
            pos   <= '0;
            neg   <= '0;
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (qx0 > qx1 || qy0 > qy1) begin
            res_est <= '0;
            res_sat <= 1'b0;
            state   <= S_OUT;
          end else begin
            bsel  <= 2'd0;
            state <= S_BND;
          end
        end
        S_BND, S_BNDW: begin
          if (big || (state == S_BNDW && dstat.done)) begin
            case (bsel)
              2'd0: xa <= bres;
              2'd1: xb <= bres;
              2'd2: ya <= bres;
              default: yb <= bres;
            endcase
            bsel <= bsel + 2'd1;
            if (bsel == 2'd3) begin
              x     <= xa;
              y     <= ya;
              state <= S_TX;
            end else begin
              state <= S_BND;
            end
          end else if (state == S_BND) begin
            state <= S_BNDW;
          end
        end
        S_TX: begin
          tx0   <= tic_at(x, nc, org_x, cwe, end_x);
          tx1   <= (x < nc) ? tic_at(x + QB'(1), nc, org_x, cwe, end_x)
                            : tic_at(x, nc, org_x, cwe, end_x);
          state <= S_TY;
        end
        S_TY: begin
          ty0   <= tic_at(y, nr, org_y, che, end_y);
          ty1   <= (y < nr) ? tic_at(y + QB'(1), nr, org_y, che, end_y)
                            : tic_at(y, nr, org_y, che, end_y);
          state <= S_EV;
        end
        S_EV: begin
          ten[0]  <= xlive && ylive;
          ten[1]  <= tx0 >= qx0 && tx0 <= qx1 && ty0 >= qy0 && ty0 <= qy1;
          ten[2]  <= xlive && ty0 > qy0 && ty0 < qy1;
          ten[3]  <= ylive && tx0 > qx0 && tx0 < qx1;
          need_fx <= xlive && ((ylive) || (ty0 > qy0 && ty0 < qy1));
          need_fy <= ylive && ((xlive) || (tx0 > qx0 && tx0 < qx1));
          ix      <= ix_c;
          iy      <= iy_c;
          lenx    <= tx1 - tx0;
          leny    <= ty1 - ty0;
          state   <= S_DX;
        end
        S_DX:  state <= need_fx ? S_DXW : S_DY;
        S_DXW: begin
          if (dstat.done) begin
            fx    <= FQ'(dquo);
            state <= S_DY;
          end
        end
        S_DY:  state <= need_fy ? S_DYW : S_FF;
        S_DYW: begin
          if (dstat.done) begin
            fy    <= FQ'(dquo);
            state <= S_FF;
          end
        end
        S_FF: begin
          tsel <= 2'd0;
          if (ten[0]) begin
            prod  <= PW'(mul_a) * PW'(mul_b);
            state <= S_FF2;
          end else begin
            state <= S_TERM;
          end
        end
        S_FF2: begin
          ff    <= FQ'(prod >> FRAC_BITS);
          state <= S_TERM;
        end
        S_TERM: begin
          if (ten[tsel]) begin
            prod  <= PW'(mul_a) * PW'(mul_b);
            state <= S_ADD;
          end else if (tsel == 2'd3) begin
            state <= S_NEXT;
          end else begin
            tsel <= tsel + 2'd1;
          end
        end
        S_ADD: begin
          if (tsel[1]) neg <= neg + ACCW'(prod);
          else         pos <= pos + ACCW'(prod);
          tsel  <= tsel + 2'd1;
          state <= (tsel == 2'd3) ? S_NEXT : S_TERM;
        end
        S_NEXT: begin
          if (y < yb) begin
            y     <= y + QB'(1);
            state <= S_TY;
          end else if (x < xb) begin
            x     <= x + QB'(1);
            y     <= ya;
            state <= S_TX;
          end else begin
            state <= S_FIN1;
          end
        end
        S_FIN1: begin
          diff  <= $signed(DFW'(pos)) - $signed(DFW'(neg));
          state <= S_FIN2;
        end
        S_FIN2: begin
          sign_r <= diff[DFW-1];
          rnd    <= (diff[DFW-1] ? $unsigned(-diff) : $unsigned(diff)) +
                    (DFW'(1) << (FRAC_BITS - 1));
          state  <= S_FIN3;
        end
        S_FIN3: begin
          res_est <= sign_r ? -$signed(mag48) : $signed(mag48);
          res_sat <= sat_c;
          state   <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || rsp.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: load when the slot is free, drop on transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && (!out_valid || rsp.ready)) begin
      out_valid <= 1'b1;
      out_est   <= res_est;
      out_sat   <= res_sat;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.estimate  = out_est;
  assign rsp.saturated = out_sat;

  ehwq_store #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .COUNT_BITS (COUNT_BITS)
  ) u_store (
    .clk     (clk),
    .wreq    (wreq),
    .clr_idx (clr_idx),
    .wx      (wx),
    .wy      (wy),
    .wdata   (COUNT_BITS'(req.count_value)),
    .rd_en   (state == S_TY),
    .rx      (x),
    .ry      (y),
    .face_q  (face_q),
    .vert_q  (vert_q),
    .hedge_q (hedge_q),
    .vedge_q (vedge_q)
  );

  ehwq_div #(
    .DW (DW),
    .QW (QW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .ctl  (dctl),
    .num  (dnum),
    .dsh  (ddsh),
    .stat (dstat),
    .quo  (dquo)
  );

  // Input stays closed during the clearing sweep
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !req.ready) else $error("ready during clear");

  // Walked cell stays inside the walk bounds
  a_walk_bounds: assert property (@(posedge clk) disable iff (rst)
    state == S_EV |-> (x <= xb && y <= yb)) else $error("walk out of bounds");

  // Divider finishes only where the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    dstat.done |-> (state == S_BNDW || state == S_DXW || state == S_DYW))
    else $error("divider result not awaited");

  // Divider never restarts while busy
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    dctl.start |-> !dstat.busy) else $error("divider restarted while busy");

endmodule

>>> rtl/ehwq_div.sv
// Shared restoring divider: one quotient bit per cycle.
module ehwq_div import ehwq_pkg::*; #(
  parameter int DW = 64,
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  div_ctl_t      ctl,
  input  logic [DW-1:0] num,
  input  logic [DW-1:0] dsh,
  output div_stat_t     stat,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] rem;
  logic [DW-1:0] dv;
  logic [5:0]    cnt;
  logic          busy;
  logic          done;

  // Load operands, then compare and subtract once per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        rem  <= num;
        dv   <= dsh;
        quo  <= '0;
        cnt  <= ctl.steps;
        busy <= 1'b1;
      end else if (busy) begin
        if (rem >= dv) begin
          rem <= rem - dv;
          quo <= {quo[QW-2:0], 1'b1};
        end else begin
          quo <= {quo[QW-2:0], 1'b0};
        end
        dv  <= dv >> 1;
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

>>> rtl/ehwq_store.sv
// Face, vertex and edge count tables with load, clear and registered read.
module ehwq_store import ehwq_pkg::*; #(
  parameter int MAX_COLS   = 64,
  parameter int MAX_ROWS   = 64,
  parameter int COUNT_BITS = 32,
  localparam int QB = ($clog2(MAX_COLS + 1) > $clog2(MAX_ROWS + 1)) ?
                      $clog2(MAX_COLS + 1) : $clog2(MAX_ROWS + 1),
  localparam int VD = (MAX_COLS + 1) * (MAX_ROWS + 1),
  localparam int CW = $clog2(VD + 1)
) (
  input  logic                  clk,
  input  wreq_t                 wreq,
  input  logic [CW-1:0]         clr_idx,
  input  logic [QB-1:0]         wx,
  input  logic [QB-1:0]         wy,
  input  logic [COUNT_BITS-1:0] wdata,
  input  logic                  rd_en,
  input  logic [QB-1:0]         rx,
  input  logic [QB-1:0]         ry,
  output logic [COUNT_BITS-1:0] face_q,
  output logic [COUNT_BITS-1:0] vert_q,
  output logic [COUNT_BITS-1:0] hedge_q,
  output logic [COUNT_BITS-1:0] vedge_q
);

  localparam int FD = MAX_COLS * MAX_ROWS;
  localparam int HD = MAX_COLS * (MAX_ROWS + 1);
  localparam int ED = (MAX_COLS + 1) * MAX_ROWS;
  localparam int AF = (FD > 1) ? $clog2(FD) : 1;
  localparam int AV = $clog2(VD);
  localparam int AH = (HD > 1) ? $clog2(HD) : 1;
  localparam int AE = $clog2(ED);

  logic [COUNT_BITS-1:0] face_mem  [FD];
  logic [COUNT_BITS-1:0] vert_mem  [VD];
  logic [COUNT_BITS-1:0] hedge_mem [HD];
  logic [COUNT_BITS-1:0] vedge_mem [ED];

  logic [AF-1:0] fa_w, fa_r;
  logic [AV-1:0] va_w, va_r;
  logic [AH-1:0] ha_w, ha_r;
  logic [AE-1:0] ea_w, ea_r;

  // Map grid coordinates to table rows
  always_comb begin
    fa_w = AF'(32'(wx) * MAX_ROWS + 32'(wy));
    va_w = AV'(32'(wx) * (MAX_ROWS + 1) + 32'(wy));
    ha_w = AH'(32'(wx) * (MAX_ROWS + 1) + 32'(wy));
    ea_w = AE'(32'(wx) * MAX_ROWS + 32'(wy));
    fa_r = AF'(32'(rx) * MAX_ROWS + 32'(ry));
    va_r = AV'(32'(rx) * (MAX_ROWS + 1) + 32'(ry));
    ha_r = AH'(32'(rx) * (MAX_ROWS + 1) + 32'(ry));
    ea_r = AE'(32'(rx) * MAX_ROWS + 32'(ry));
  end

  // Clear sweep or single load
  always_ff @(posedge clk) begin
    if (wreq.clear) begin
      if (32'(clr_idx) < FD) face_mem[AF'(clr_idx)] <= '0;
      if (32'(clr_idx) < VD) vert_mem[AV'(clr_idx)] <= '0;
      if (32'(clr_idx) < HD) hedge_mem[AH'(clr_idx)] <= '0;
      if (32'(clr_idx) < ED) vedge_mem[AE'(clr_idx)] <= '0;
    end else begin
      if (wreq.sel[SEL_FACE])  face_mem[fa_w]  <= wdata;
      if (wreq.sel[SEL_VERT])  vert_mem[va_w]  <= wdata;
      if (wreq.sel[SEL_HEDGE]) hedge_mem[ha_w] <= wdata;
      if (wreq.sel[SEL_VEDGE]) vedge_mem[ea_w] <= wdata;
    end
  end

  // Registered read of all four tables at one cell
  always_ff @(posedge clk) begin
    if (rd_en) begin
      face_q  <= face_mem[fa_r];
      vert_q  <= vert_mem[va_r];
      hedge_q <= hedge_mem[ha_r];
      vedge_q <= vedge_mem[ea_r];
    end
  end

endmodule
